[rtl/socd_pkg.sv]
`default_nettype none

package socd_pkg;

    // Defaults for the top-level parameters
    localparam int TICK_BITS_DEF  = 64;
    localparam int MID_DEPTH_DEF  = 2;
    localparam int OUT_DEPTH_DEF  = 2;

    // Fixed port width of the tick fields
    localparam int PORT_TICK_BITS = 64;

    // Button direction codes
    typedef enum logic [1:0] {
        DIR_POS  = 2'd0,
        DIR_NEU  = 2'd1,
        DIR_NEG  = 2'd2,
        DIR_RSVD = 2'd3
    } dir_t;

    // Resolution modes
    typedef enum logic [1:0] {
        MODE_NEUTRAL   = 2'd0,
        MODE_POS_PRIO  = 2'd1,
        MODE_NEG_PRIO  = 2'd2,
        MODE_LAST_WINS = 2'd3
    } mode_t;

    // What a queued word asks the back end to do
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_OVERRIDE = 2'd2
    } kind_t;

    // Axis values, 2-bit two's complement
    localparam logic [1:0] VAL_POS  = 2'b01;
    localparam logic [1:0] VAL_ZERO = 2'b00;
    localparam logic [1:0] VAL_NEG  = 2'b11;

    // Control part of a classified word
    typedef struct packed {
        kind_t kind;
        dir_t  dir;
        logic  last;
    } item_ctl_t;

    // Direction to axis value
    function automatic logic [1:0] dir_value(dir_t d);
        logic [1:0] v;
        case (d)
            DIR_POS: v = VAL_POS;
            DIR_NEG: v = VAL_NEG;
            default: v = VAL_ZERO;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/socd_fifo.sv]
`default_nettype none

module socd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[rtl/socd_front.sv]
`default_nettype none

module socd_front #(
    parameter int TICK_BITS = socd_pkg::TICK_BITS_DEF
) (
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                pressed,
    input  wire logic                                overrides,
    input  wire logic [1:0]                          direction,
    input  wire logic [socd_pkg::PORT_TICK_BITS-1:0] press_tick,
    input  wire logic                                last_button,
    input  wire logic                                mid_full,
    output logic                                     mid_push,
    output socd_pkg::item_ctl_t                      mid_ctl,
    output logic [TICK_BITS-1:0]                     mid_tick
);

    import socd_pkg::*;

    logic usable;

    // Released buttons and the reserved direction carry no update
    assign usable = pressed && (dir_t'(direction) != DIR_RSVD);

    // Classify the word
    always_comb
    begin
        mid_ctl.dir  = dir_t'(direction);
        mid_ctl.last = last_button;
        if (!usable)
        begin
            mid_ctl.kind = KIND_NONE;
        end
        else if (overrides)
        begin
            mid_ctl.kind = KIND_OVERRIDE;
        end
        else
        begin
            mid_ctl.kind = KIND_TICK;
        end
    end

    assign mid_tick = press_tick[TICK_BITS-1:0];

    // Words that do nothing and end no run are dropped here
    assign full     = mid_full;
    assign mid_push = push && !mid_full && (usable || last_button);

endmodule

`default_nettype wire

[rtl/socd_back.sv]
`default_nettype none

module socd_back #(
    parameter int TICK_BITS = socd_pkg::TICK_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire socd_pkg::mode_t      mode,
    input  wire logic                 mid_empty,
    input  wire socd_pkg::item_ctl_t  mid_ctl,
    input  wire logic [TICK_BITS-1:0] mid_tick,
    output logic                      mid_pop,
    input  wire logic                 out_full,
    output logic                      out_push,
    output logic [1:0]                out_value,
    output logic [TICK_BITS-1:0]      out_tick
);

    import socd_pkg::*;

    // Run state
    logic [TICK_BITS-1:0] tick_reg [3];
    logic [TICK_BITS-1:0] tick_next [3];
    logic [2:0]           seen_reg, seen_next;
    logic                 lock_reg, lock_next;
    logic [1:0]           oval_reg, oval_next;
    logic [TICK_BITS-1:0] otick_reg, otick_next;

    // Snapshot of a finished run, waiting for resolution
    logic                 snap_valid_reg, snap_valid_next;
    logic [TICK_BITS-1:0] snap_tick_reg [3];
    logic [2:0]           snap_seen_reg;
    logic                 snap_lock_reg;
    logic [1:0]           snap_oval_reg;
    logic [TICK_BITS-1:0] snap_otick_reg;

    logic [TICK_BITS-1:0] tick_upd [3];
    logic [2:0]           hit;
    logic                 ovr_hit;
    logic                 run_end;
    logic                 snap_free;

    // Take a word unless it ends a run and the snapshot slot stays busy
    assign snap_free = !snap_valid_reg || !out_full;
    assign mid_pop   = !mid_empty && (!mid_ctl.last || snap_free);
    assign run_end   = mid_pop && mid_ctl.last;
    assign ovr_hit   = mid_pop && !lock_reg && (mid_ctl.kind == KIND_OVERRIDE);

    // Per-direction newest tick, replaced only by a strictly greater one
    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            hit[d] = mid_pop && !lock_reg && (mid_ctl.kind == KIND_TICK)
                     && (mid_ctl.dir == dir_t'(2'(d)))
                     && (!seen_reg[d] || (tick_reg[d] < mid_tick));
            tick_upd[d] = hit[d] ? mid_tick : tick_reg[d];
        end
    end

    // Next run state; cleared at the end of a run
    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            tick_next[d] = run_end ? '0 : tick_upd[d];
        end
        seen_next  = run_end ? 3'b000 : (seen_reg | hit);
        lock_next  = run_end ? 1'b0 : (lock_reg | ovr_hit);
        oval_next  = run_end ? VAL_ZERO : (ovr_hit ? dir_value(mid_ctl.dir) : oval_reg);
        otick_next = run_end ? '0 : (ovr_hit ? mid_tick : otick_reg);
    end

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (run_end)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_valid_reg && !out_full)
        begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < 3; d++)
            begin
                tick_reg[d] <= '0;
            end
            seen_reg       <= '0;
            lock_reg       <= 1'b0;
            oval_reg       <= VAL_ZERO;
            otick_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            for (int d = 0; d < 3; d++)
            begin
                tick_reg[d] <= tick_next[d];
            end
            seen_reg       <= seen_next;
            lock_reg       <= lock_next;
            oval_reg       <= oval_next;
            otick_reg      <= otick_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    // Snapshot payload, captured with the post-update run state
    always_ff @(posedge clk)
    begin
        if (run_end)
        begin
            for (int d = 0; d < 3; d++)
            begin
                snap_tick_reg[d] <= tick_upd[d];
            end
            snap_seen_reg  <= seen_reg | hit;
            snap_lock_reg  <= lock_reg | ovr_hit;
            snap_oval_reg  <= ovr_hit ? dir_value(mid_ctl.dir) : oval_reg;
            snap_otick_reg <= ovr_hit ? mid_tick : otick_reg;
        end
    end

    // Resolution: parallel compares, then selection
    logic                 p_seen, u_seen, n_seen;
    logic                 pos_ge_neu, pos_ge_neg, neu_ge_neg, tp_gt_tn;
    logic [TICK_BITS-1:0] tp, tn;

    assign p_seen     = snap_seen_reg[DIR_POS];
    assign u_seen     = snap_seen_reg[DIR_NEU];
    assign n_seen     = snap_seen_reg[DIR_NEG];
    assign tp         = p_seen ? snap_tick_reg[DIR_POS] : '0;
    assign tn         = n_seen ? snap_tick_reg[DIR_NEG] : '0;
    assign tp_gt_tn   = tp > tn;
    assign pos_ge_neu = snap_tick_reg[DIR_POS] >= snap_tick_reg[DIR_NEU];
    assign pos_ge_neg = snap_tick_reg[DIR_POS] >= snap_tick_reg[DIR_NEG];
    assign neu_ge_neg = snap_tick_reg[DIR_NEU] >= snap_tick_reg[DIR_NEG];

    always_comb
    begin
        out_value = VAL_ZERO;
        out_tick  = '0;
        if (snap_lock_reg)
        begin
            out_value = snap_oval_reg;
            out_tick  = snap_otick_reg;
        end
        else
        begin
            case (mode)
                MODE_NEUTRAL:
                begin
                    if (p_seen && !n_seen)
                    begin
                        out_value = VAL_POS;
                    end
                    else if (n_seen && !p_seen)
                    begin
                        out_value = VAL_NEG;
                    end
                    out_tick = tp_gt_tn ? tp : tn;
                end
                MODE_POS_PRIO:
                begin
                    if (p_seen)
                    begin
                        out_value = VAL_POS;
                        out_tick  = snap_tick_reg[DIR_POS];
                    end
                    else if (n_seen)
                    begin
                        out_value = VAL_NEG;
                        out_tick  = snap_tick_reg[DIR_NEG];
                    end
                end
                MODE_NEG_PRIO:
                begin
                    if (n_seen)
                    begin
                        out_value = VAL_NEG;
                        out_tick  = snap_tick_reg[DIR_NEG];
                    end
                    else if (p_seen)
                    begin
                        out_value = VAL_POS;
                        out_tick  = snap_tick_reg[DIR_POS];
                    end
                end
                default:
                begin
                    // newest press wins; ties prefer positive, then neutral
                    if (p_seen && (!u_seen || pos_ge_neu) && (!n_seen || pos_ge_neg))
                    begin
                        out_value = VAL_POS;
                        out_tick  = snap_tick_reg[DIR_POS];
                    end
                    else if (u_seen && (!n_seen || neu_ge_neg))
                    begin
                        out_value = VAL_ZERO;
                        out_tick  = snap_tick_reg[DIR_NEU];
                    end
                    else if (n_seen)
                    begin
                        out_value = VAL_NEG;
                        out_tick  = snap_tick_reg[DIR_NEG];
                    end
                end
            endcase
        end
    end

    assign out_push = snap_valid_reg && !out_full;

endmodule

`default_nettype wire

[rtl/socd_axis_resolver_core.sv]
// SOCD axis resolver: settles opposing directions on one stick axis.
//
// Input side is a queue: drive a button word on pressed, overrides,
// direction, press_tick and last_button with push high; it is taken at a
// clock edge where full is low. A run of words ends with last_button set,
// and that word yields one result. Result side is a queue too: while empty
// is low, axis_value and axis_tick show the oldest result; pop takes it.
// resolve_mode_we writes resolve_mode_wdata to the mode register; write it
// only while no run is in flight.
//
// Throughput: one word per cycle while full is low. The classifier feeds a
// small queue to the state-update stage; a finished run is snapshotted,
// resolved combinationally from the snapshot and written to the result
// queue once it has room, where it then becomes visible on the outputs.
// When pop stays low the result queue fills, the snapshot holds, the middle
// queue backs up and full rises; nothing is lost.
// Reset clears the run state, both queues and the mode (neutral cancel).
`default_nettype none

module socd_axis_resolver_core #(
    parameter int TICK_BITS = socd_pkg::TICK_BITS_DEF,
    parameter int MID_DEPTH = socd_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = socd_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                pressed,
    input  wire logic                                overrides,
    input  wire logic [1:0]                          direction,
    input  wire logic [socd_pkg::PORT_TICK_BITS-1:0] press_tick,
    input  wire logic                                last_button,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [1:0]                        axis_value,
    output logic [socd_pkg::PORT_TICK_BITS-1:0]      axis_tick,
    input  wire logic                                resolve_mode_we,
    input  wire logic [1:0]                          resolve_mode_wdata
);

    import socd_pkg::*;

    localparam int MID_W = $bits(item_ctl_t) + TICK_BITS;
    localparam int OUT_W = 2 + TICK_BITS;

    // Mode register
    mode_t mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NEUTRAL;
        end
        else if (resolve_mode_we)
        begin
            mode_reg <= mode_t'(resolve_mode_wdata);
        end
    end

    // Front end
    logic                 mid_push, mid_full, mid_pop, mid_empty;
    item_ctl_t            front_ctl, back_ctl;
    logic [TICK_BITS-1:0] front_tick, back_tick;
    logic [MID_W-1:0]     mid_rdata;

    socd_front #(
        .TICK_BITS (TICK_BITS)
    ) u_front (
        .push        (push),
        .full        (full),
        .pressed     (pressed),
        .overrides   (overrides),
        .direction   (direction),
        .press_tick  (press_tick),
        .last_button (last_button),
        .mid_full    (mid_full),
        .mid_push    (mid_push),
        .mid_ctl     (front_ctl),
        .mid_tick    (front_tick)
    );

    // Queue between front and back
    socd_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata ({front_ctl, front_tick}),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign {back_ctl, back_tick} = mid_rdata;

    // Back end
    logic                 out_push, out_full;
    logic [1:0]           res_value;
    logic [TICK_BITS-1:0] res_tick;
    logic [OUT_W-1:0]     out_rdata;

    socd_back #(
        .TICK_BITS (TICK_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .mid_empty (mid_empty),
        .mid_ctl   (back_ctl),
        .mid_tick  (back_tick),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_value (res_value),
        .out_tick  (res_tick)
    );

    // Result queue
    socd_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata ({res_value, res_tick}),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign axis_value = signed'(out_rdata[OUT_W-1 -: 2]);
    assign axis_tick  = PORT_TICK_BITS'(out_rdata[TICK_BITS-1:0]);

endmodule

`default_nettype wire

[rtl/socd_axis_resolver_checker.sv]
`default_nettype none

module socd_axis_resolver_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                push,
    input wire logic                                full,
    input wire logic                                empty,
    input wire logic                                pop,
    input wire logic signed [1:0]                   axis_value,
    input wire logic [socd_pkg::PORT_TICK_BITS-1:0] axis_tick
);

    // While a result waits, the axis value is -1, 0 or +1
    a_value_legal: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (axis_value != 2'sb10)
    ) else $error("axis_value holds the unused code");

    // A waiting result is held until popped
    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(axis_value) && $stable(axis_tick))
    ) else $error("waiting result changed or vanished");

    // The input side only fills because of an accepted word
    a_full_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full)
    ) else $error("full rose without an accepted word");

endmodule

bind socd_axis_resolver_core socd_axis_resolver_checker u_checker (.*);

`default_nettype wire
